[hdl/extended_gcd_bezout_macros.svh]
// Assertion macros for the checker file of the extended gcd block.
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define EGB_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked check that a condition never holds.
`define EGB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `EGB_ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

[hdl/egb_pkg.sv]
// Package of the extended gcd block: channel widths and the sequencer state type.
`default_nettype none

package egb_pkg;

  localparam int OPERAND_W  = 31;  // width of operand_a and operand_b
  localparam int DIVISOR_W  = 31;  // width of the gcd result field
  localparam int COEF_W     = 32;  // width of each Bezout coefficient
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 96;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } egb_state_t;

endpackage

`default_nettype wire

[hdl/egb_div_unit.sv]
// Shared restoring divider, one quotient bit a cycle, with a shift-add quotient multiply.
`default_nettype none

module egb_div_unit #(
  parameter int DATA_WIDTH = 31
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [DATA_WIDTH-1:0]         dividend,
  input  wire logic [DATA_WIDTH-1:0]         divisor,
  input  wire logic [egb_pkg::COEF_W-1:0]    mul_a,
  input  wire logic [egb_pkg::COEF_W-1:0]    mul_b,
  output logic                               done,
  output logic [DATA_WIDTH-1:0]              remainder,
  output logic [egb_pkg::COEF_W-1:0]         prod_a,
  output logic [egb_pkg::COEF_W-1:0]         prod_b
);

  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);
  localparam int CW = egb_pkg::COEF_W;

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] dvd_r;
  logic [DATA_WIDTH-1:0] dsr_r;
  logic [CW-1:0]         ma_r;
  logic [CW-1:0]         mb_r;
  logic [CW-1:0]         acc_a_r;
  logic [CW-1:0]         acc_b_r;

  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] dvd_nxt;
  logic [CW-1:0]         acc_a_nxt;
  logic [CW-1:0]         acc_b_nxt;
  logic                  last_step;

  // Bring down the next dividend bit and try the subtract.
  always_comb begin
    trial     = {rem_r, dvd_r[DATA_WIDTH-1]};
    diff      = trial - {1'b0, dsr_r};
    qbit      = ~diff[DATA_WIDTH];
    rem_nxt   = qbit ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
    dvd_nxt   = {dvd_r[DATA_WIDTH-2:0], 1'b0};
    acc_a_nxt = {acc_a_r[CW-2:0], 1'b0} + (qbit ? ma_r : '0);
    acc_b_nxt = {acc_b_r[CW-2:0], 1'b0} + (qbit ? mb_r : '0);
    last_step = busy_r && (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= LAST_STEP;
      end else if (busy_r) begin
        if (last_step) begin
          busy_r <= 1'b0;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= '0;
      dvd_r   <= dividend;
      dsr_r   <= divisor;
      ma_r    <= mul_a;
      mb_r    <= mul_b;
      acc_a_r <= '0;
      acc_b_r <= '0;
    end else if (busy_r) begin
      rem_r   <= rem_nxt;
      dvd_r   <= dvd_nxt;
      acc_a_r <= acc_a_nxt;
      acc_b_r <= acc_b_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;
  assign prod_a    = acc_a_r;
  assign prod_b    = acc_b_r;

endmodule

`default_nettype wire

[hdl/extended_gcd_bezout.sv]
// Top level of the extended gcd block: stream ports, step sequencer and coefficient pairs.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   in_     | in  | in_tvalid/tready   | in_tdata: operand_a, operand_b
//   out_    | out | out_tvalid/tready  | out_tdata: divisor, coef_a, coef_b
//
// out_tvalid rises once all quotient steps of a request are done (at most about 46 for
// 31-bit operands); the next request can be taken from that same cycle, in the idle state.
// Each step passes through the check state, then the divider works out DATA_WIDTH
// quotient bits and raises its done strobe.
// in_tready is high only while the sequencer is idle; a finished result sits in the
// output register, so the next request is taken while the result waits for out_tready.
// rst_n is synchronous and active low; it clears the sequencer and the output valid,
// and in_tready stays low while it is asserted.
`default_nettype none

module extended_gcd_bezout #(
  parameter int DATA_WIDTH = 31
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [30:0] operand_a, [61:31] operand_b, [63:62] zero
  input  wire logic [egb_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [30:0] divisor, [62:31] coef_a, [94:63] coef_b, [95] zero
  output logic [egb_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int CW = egb_pkg::COEF_W;
  localparam int OW = egb_pkg::OPERAND_W;

  egb_pkg::egb_state_t state_r;
  egb_pkg::egb_state_t state_nxt;

  // Remainder pair and coefficient pairs of the running recurrence.
  logic [DATA_WIDTH-1:0] rem_hi_r;
  logic [DATA_WIDTH-1:0] rem_lo_r;
  logic [CW-1:0]         xa_r;
  logic [CW-1:0]         xb_r;
  logic [CW-1:0]         ya_r;
  logic [CW-1:0]         yb_r;

  // Output register.
  logic                          out_valid_r;
  logic [egb_pkg::DIVISOR_W-1:0] out_div_r;
  logic [CW-1:0]                 out_ca_r;
  logic [CW-1:0]                 out_cb_r;

  logic [OW-1:0]         operand_a;
  logic [OW-1:0]         operand_b;
  logic                  accept;
  logic                  rem_zero;
  logic                  div_start;
  logic                  out_load;
  logic                  div_done;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [CW-1:0]         prod_a;
  logic [CW-1:0]         prod_b;

  assign operand_a = in_tdata[OW-1:0];
  assign operand_b = in_tdata[2*OW-1:OW];
  assign rem_zero  = (rem_lo_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      egb_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = egb_pkg::ST_CHECK;
        end
      end
      egb_pkg::ST_CHECK: begin
        if (!rem_zero) begin
          state_nxt = egb_pkg::ST_DIV;
        end else if (!out_valid_r || out_tready) begin
          state_nxt = egb_pkg::ST_IDLE;
        end
      end
      egb_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = egb_pkg::ST_CHECK;
        end
      end
      default: state_nxt = egb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      egb_pkg::ST_IDLE:  in_tready = rst_n;
      egb_pkg::ST_CHECK: begin
        div_start = !rem_zero;
        // Hold the finished result until the output register frees up.
        out_load  = rem_zero && (!out_valid_r || out_tready);
      end
      egb_pkg::ST_DIV:   ;
      default:           ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the operands, then advance the recurrence once per finished division.
  always_ff @(posedge clk) begin
    if (accept) begin
      rem_hi_r <= DATA_WIDTH'(operand_a);
      rem_lo_r <= DATA_WIDTH'(operand_b);
      xa_r     <= CW'(1);
      xb_r     <= '0;
      ya_r     <= '0;
      yb_r     <= CW'(1);
    end else if ((state_r == egb_pkg::ST_DIV) && div_done) begin
      rem_hi_r <= rem_lo_r;
      rem_lo_r <= div_rem;
      xa_r     <= xb_r;
      xb_r     <= xa_r - prod_a;
      ya_r     <= yb_r;
      yb_r     <= ya_r - prod_b;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_div_r <= egb_pkg::DIVISOR_W'(rem_hi_r);
      out_ca_r  <= xa_r;
      out_cb_r  <= ya_r;
    end
  end

  // Shared divider: quotient of rem_hi by rem_lo, remainder, and quotient times xb, yb.
  egb_div_unit #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rem_hi_r),
    .divisor   (rem_lo_r),
    .mul_a     (xb_r),
    .mul_b     (yb_r),
    .done      (div_done),
    .remainder (div_rem),
    .prod_a    (prod_a),
    .prod_b    (prod_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_cb_r, out_ca_r, out_div_r};

endmodule

`default_nettype wire

[hdl/egb_checker.sv]
// Port-level checker of the extended gcd block and its bind to the top level.
`default_nettype none
`include "extended_gcd_bezout_macros.svh"

module egb_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [egb_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [egb_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready && (in_tdata[egb_pkg::IN_TDATA_W-1] == 1'b0);
  assign out_stall = out_tvalid && !out_tready;

  // A stalled result stays offered and unchanged.
  `EGB_ASSERT_CLK(a_out_hold, clk, rst_n, out_stall |=> out_tvalid, "result dropped while stalled")
  `EGB_ASSERT_CLK(a_out_stable, clk, rst_n, out_stall |=> $stable(out_tdata), "result changed while stalled")
  // The block goes busy right after taking a request.
  `EGB_ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_acc |=> !in_tready, "ready after accept")
  // A result only appears when the block was busy beforehand, never straight out of idle.
  `EGB_ASSERT_NEVER(a_out_from_busy, clk, rst_n, $rose(out_tvalid) && $past(in_tready), "result while idle")

endmodule

bind extended_gcd_bezout egb_checker u_egb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
